FILE: sv/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants for the circular list manager
// Request and response layouts, status and operation codes, sequencer states.
// ----------------------------------------------------------------------------
package clm_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [VALUE_W-1:0] val_type;

   typedef enum logic [1:0] {
      FUNC_INS_HEAD = 2'd0,
      FUNC_INS_TAIL = 2'd1,
      FUNC_DELETE   = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [6:0]         node_count;
      logic signed [31:0] head_value;
      logic signed [31:0] tail_value;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_START,
      ST_INS_POP,
      ST_INS_FIX,
      ST_DEL_START,
      ST_DEL_HLINK,
      ST_DEL_HVAL,
      ST_DEL_STEP,
      ST_DEL_CMP,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/clm_ram.sv
// ----------------------------------------------------------------------------
// clm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module clm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/circular_list_manager.sv
// ----------------------------------------------------------------------------
// circular_list_manager: circular singly linked list over a fixed node store
// Inserts at head or tail, or deletes the first matching value, and reports
// status, node count and the head and tail values after every request.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on req_data and raise start; it is taken at the rising
//   edge where start is high and busy is low. busy stays high while the
//   request is worked on. Exactly one response follows each request: it is on
//   rsp_data for one cycle, marked by rsp_valid, and the receiver has no way
//   to hold it off. busy drops in the same cycle that rsp_valid rises, so the
//   next request may be taken while the response is on the ports.
//   A delete that walks the ring examines one node per cycle, a rate set by
//   the registered read of the node value and link stores.
//   Reset empties the list and makes every node free at once; no clearing
//   pass is needed, since the free stack reads as its reset order until each
//   entry is written.
// ----------------------------------------------------------------------------
module circular_list_manager
   import clm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Sequencer and list registers
   state_type  state_ff, state_in;
   req_type    item_ff, item_in;
   status_type status_ff, status_in;
   cnt_type    free_top_ff, free_top_in;
   cnt_type    count_ff, count_in;
   cnt_type    step_ff, step_in;
   idx_type    head_ff, head_in;
   idx_type    tail_ff, tail_in;
   idx_type    cur_ff, cur_in;
   idx_type    nxt_ff, nxt_in;
   idx_type    node_ff, node_in;
   val_type    head_val_ff, head_val_in;
   val_type    tail_val_ff, tail_val_in;
   val_type    cur_val_ff, cur_val_in;
   logic [CAPACITY-1:0] fs_valid_ff, fs_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // Store ports
   logic    val_we, link_we, fs_we;
   idx_type val_wa, link_wa, fs_wa;
   val_type val_wd;
   idx_type link_wd, fs_wd;
   idx_type val_ra, link_ra, fs_ra;
   val_type val_rd;
   idx_type link_rd, fs_rd;

   // Shared value comparator and free stack helpers
   val_type cmp_a;
   logic    cmp_hit;
   cnt_type top_dec;
   idx_type fs_pos;
   idx_type popped;
   cnt_type step_inc;

   assign top_dec  = free_top_ff - cnt_type'(1);
   assign fs_pos   = top_dec[IDX_W-1:0];
   assign popped   = fs_valid_ff[fs_pos] ? fs_rd : fs_pos;
   assign step_inc = step_ff + cnt_type'(1);
   assign cmp_a    = (state_ff == ST_DEL_START) ? head_val_ff : val_rd;
   assign cmp_hit  = (cmp_a == val_type'(item_ff.item_value));

   clm_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (val_ra),
      .rd_data (val_rd)
   );

   clm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   clm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_stack (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_wa),
      .wr_data (fs_wd),
      .rd_addr (fs_ra),
      .rd_data (fs_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_top_ff  <= cnt_type'(CAPACITY);
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fs_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_top_ff  <= free_top_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fs_valid_ff  <= fs_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      status_ff   <= status_in;
      step_ff     <= step_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      node_ff     <= node_in;
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      cur_val_ff  <= cur_val_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      status_in    = status_ff;
      free_top_in  = free_top_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      node_in      = node_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      cur_val_in   = cur_val_ff;
      fs_valid_in  = fs_valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      val_we  = 1'b0;
      val_wa  = node_ff;
      val_wd  = val_type'(item_ff.item_value);
      val_ra  = head_ff;
      link_we = 1'b0;
      link_wa = node_ff;
      link_wd = head_ff;
      link_ra = head_ff;
      fs_we   = 1'b0;
      fs_wa   = free_top_ff[IDX_W-1:0];
      fs_wd   = head_ff;
      fs_ra   = fs_pos;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in   = req_data;
               status_in = STATUS_OK;
               case (req_data.func)
                  FUNC_INS_HEAD, FUNC_INS_TAIL: state_in = ST_INS_START;
                  FUNC_DELETE:                  state_in = ST_DEL_START;
                  default:                      state_in = ST_FINISH;
               endcase
            end
         end

         // Refuse when the free stack is drained; else its top is read
         ST_INS_START: begin
            if (free_top_ff == '0) begin
               status_in = STATUS_FULL;
               state_in  = ST_FINISH;
            end else begin
               state_in = ST_INS_POP;
            end
         end

         // Pop a node, fill its value and its forward link
         ST_INS_POP: begin
            node_in     = popped;
            free_top_in = top_dec;
            val_we      = 1'b1;
            val_wa      = popped;
            link_we     = 1'b1;
            link_wa     = popped;
            if (count_ff == '0) begin
               link_wd     = popped;
               head_in     = popped;
               tail_in     = popped;
               head_val_in = val_type'(item_ff.item_value);
               tail_val_in = val_type'(item_ff.item_value);
               count_in    = count_ff + cnt_type'(1);
               state_in    = ST_FINISH;
            end else begin
               link_wd = head_ff;
               if (item_ff.func == FUNC_INS_HEAD) begin
                  head_in     = popped;
                  head_val_in = val_type'(item_ff.item_value);
               end
               state_in = ST_INS_FIX;
            end
         end

         // Close the ring: old tail points at the new node
         ST_INS_FIX: begin
            link_we  = 1'b1;
            link_wa  = tail_ff;
            link_wd  = node_ff;
            count_in = count_ff + cnt_type'(1);
            if (item_ff.func == FUNC_INS_TAIL) begin
               tail_in     = node_ff;
               tail_val_in = val_type'(item_ff.item_value);
            end
            state_in = ST_FINISH;
         end

         // Check the head against the held head value; link[head] is read
         ST_DEL_START: begin
            link_ra = head_ff;
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
               state_in  = ST_FINISH;
            end else if (cmp_hit) begin
               if (count_ff == cnt_type'(1)) begin
                  fs_we       = 1'b1;
                  fs_wd       = head_ff;
                  fs_valid_in[free_top_ff[IDX_W-1:0]] = 1'b1;
                  free_top_in = free_top_ff + cnt_type'(1);
                  head_in     = '0;
                  tail_in     = '0;
                  count_in    = '0;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_DEL_HLINK;
               end
            end else if (count_ff == cnt_type'(1)) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FINISH;
            end else begin
               cur_in     = head_ff;
               cur_val_in = head_val_ff;
               step_in    = cnt_type'(1);
               state_in   = ST_DEL_STEP;
            end
         end

         // Drop the head: advance head, relink tail, free the old head
         ST_DEL_HLINK: begin
            link_we     = 1'b1;
            link_wa     = tail_ff;
            link_wd     = link_rd;
            val_ra      = link_rd;
            fs_we       = 1'b1;
            fs_wd       = head_ff;
            fs_valid_in[free_top_ff[IDX_W-1:0]] = 1'b1;
            free_top_in = free_top_ff + cnt_type'(1);
            head_in     = link_rd;
            count_in    = count_ff - cnt_type'(1);
            state_in    = ST_DEL_HVAL;
         end

         ST_DEL_HVAL: begin
            head_val_in = val_rd;
            state_in    = ST_FINISH;
         end

         // First successor of the head is known: read its value and link
         ST_DEL_STEP: begin
            nxt_in   = link_rd;
            val_ra   = link_rd;
            link_ra  = link_rd;
            state_in = ST_DEL_CMP;
         end

         // One node per cycle: compare, and fetch the next one meanwhile
         ST_DEL_CMP: begin
            val_ra  = link_rd;
            link_ra = link_rd;
            if (cmp_hit) begin
               link_we     = 1'b1;
               link_wa     = cur_ff;
               link_wd     = link_rd;
               fs_we       = 1'b1;
               fs_wd       = nxt_ff;
               fs_valid_in[free_top_ff[IDX_W-1:0]] = 1'b1;
               free_top_in = free_top_ff + cnt_type'(1);
               count_in    = count_ff - cnt_type'(1);
               if (nxt_ff == tail_ff) begin
                  tail_in     = cur_ff;
                  tail_val_in = cur_val_ff;
               end
               state_in = ST_FINISH;
            end else if (step_inc == count_ff) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FINISH;
            end else begin
               step_in    = step_inc;
               cur_in     = nxt_ff;
               cur_val_in = val_rd;
               nxt_in     = link_rd;
            end
         end

         // Load the response registers; the strobe follows next cycle
         ST_FINISH: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.node_count  = 7'(count_ff);
            if (count_ff == '0) begin
               rsp_in.head_value = '0;
               rsp_in.tail_value = '0;
            end else begin
               rsp_in.head_value = 32'(head_val_ff);
               rsp_in.tail_value = 32'(tail_val_ff);
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every node is either linked or on the free stack between requests
   a_node_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((count_ff + free_top_ff) == cnt_type'(CAPACITY)))
      else $error("node count and free stack depth disagree");

   // A response strobe only follows the finishing step
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("response strobe without a finished request");

   // An accepted request makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // A refused insert only happens on a full store
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL)
         |-> (rsp_data.node_count == 7'(CAPACITY)))
      else $error("store full reported with free nodes left");

   // An empty list reports zero values
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.node_count == '0)
         |-> (rsp_data.head_value == '0 && rsp_data.tail_value == '0))
      else $error("empty list reports non-zero values");

endmodule

FILE: sim/list_response_checker.sv
// ----------------------------------------------------------------------------
// list_response_checker: response predictor and scoreboard for the list manager
// Watches both channels, keeps its own copy of the node store, free stack and
// ring pointers, and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module list_response_checker
   import clm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_responses,
   output int      requests_seen,
   output int      refused_inserts,
   output int      empty_deletes,
   output int      missed_deletes,
   output int      peak_nodes
);

   val_type node_val   [CAPACITY];
   idx_type node_link  [CAPACITY];
   idx_type free_stack [CAPACITY];
   cnt_type free_top;
   idx_type head_idx;
   idx_type tail_idx;
   cnt_type list_count;

   rsp_type expected_responses [$];
   rsp_type oldest_expected;
   rsp_type predicted;
   int      responses_seen;

   task automatic report_mismatch(input string msg);
      // quieten after the first forty, keep counting
      if (mismatch_count < 40)
         $display("[%0t] response %0d: %s", $realtime, responses_seen, msg);
      mismatch_count++;
   endtask

   function automatic void free_node(input idx_type n);
      free_stack[free_top] = n;
      free_top++;
      list_count--;
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type    res;
      status_type st;
      idx_type    n;
      idx_type    cur;
      idx_type    nxt;
      bit         found;
      int         k;
      st = STATUS_OK;
      case (r.func)
         FUNC_INS_HEAD, FUNC_INS_TAIL: begin
            if (free_top == 0) begin
               st = STATUS_FULL;
            end else begin
               free_top--;
               n = free_stack[free_top];
               node_val[n] = r.item_value;
               if (list_count == 0) begin
                  head_idx     = n;
                  tail_idx     = n;
                  node_link[n] = n;
               end else if (r.func == FUNC_INS_HEAD) begin
                  node_link[n]        = head_idx;
                  head_idx            = n;
                  node_link[tail_idx] = n;
               end else begin
                  node_link[tail_idx] = n;
                  tail_idx            = n;
                  node_link[n]        = head_idx;
               end
               list_count++;
            end
         end
         FUNC_DELETE: begin
            if (list_count == 0) begin
               st = STATUS_EMPTY;
            end else begin
               cur = head_idx;
               if (node_val[cur] == r.item_value) begin
                  if (list_count == 1) begin
                     head_idx = '0;
                     tail_idx = '0;
                  end else begin
                     nxt                 = node_link[cur];
                     node_link[tail_idx] = nxt;
                     head_idx            = nxt;
                  end
                  free_node(cur);
               end else begin
                  // walk the ring; the tail moves back if it is the victim
                  found = 1'b0;
                  for (k = 1; k < list_count && !found; k++) begin
                     nxt = node_link[cur];
                     if (node_val[nxt] == r.item_value) begin
                        node_link[cur] = node_link[nxt];
                        if (nxt == tail_idx)
                           tail_idx = cur;
                        free_node(nxt);
                        found = 1'b1;
                     end else begin
                        cur = nxt;
                     end
                  end
                  if (!found)
                     st = STATUS_NOT_FOUND;
               end
            end
         end
         default: ;
      endcase
      res.status     = st;
      res.node_count = list_count;
      res.head_value = (list_count == 0) ? '0 : node_val[head_idx];
      res.tail_value = (list_count == 0) ? '0 : node_val[tail_idx];
      return res;
   endfunction

   task automatic compare_response(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         report_mismatch($sformatf("status got %0d, expected %0d", got.status, want.status));
      if (got.node_count !== want.node_count)
         report_mismatch($sformatf("node_count got %0d, expected %0d",
                                   got.node_count, want.node_count));
      if (got.head_value !== want.head_value)
         report_mismatch($sformatf("head_value got %0d, expected %0d",
                                   got.head_value, want.head_value));
      if (got.tail_value !== want.tail_value)
         report_mismatch($sformatf("tail_value got %0d, expected %0d",
                                   got.tail_value, want.tail_value));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++)
            free_stack[i] = idx_type'(i);
         free_top          = cnt_type'(CAPACITY);
         head_idx          = '0;
         tail_idx          = '0;
         list_count        = '0;
         expected_responses.delete();
         mismatch_count    = 0;
         pending_responses = 0;
         requests_seen     = 0;
         responses_seen    = 0;
         refused_inserts   = 0;
         empty_deletes     = 0;
         missed_deletes    = 0;
         peak_nodes        = 0;
      end else begin
         // retire the response first: it always belongs to an earlier request
         if (rsp_valid === 1'b1) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               oldest_expected = expected_responses.pop_front();
               compare_response(rsp_data, oldest_expected);
            end
            responses_seen++;
         end
         if (start && busy === 1'b0) begin
            predicted = predict_response(req_data);
            expected_responses.push_back(predicted);
            requests_seen++;
            case (predicted.status)
               STATUS_FULL:      refused_inserts++;
               STATUS_EMPTY:     empty_deletes++;
               STATUS_NOT_FOUND: missed_deletes++;
               default: ;
            endcase
            if (int'(list_count) > peak_nodes)
               peak_nodes = int'(list_count);
         end
         pending_responses = expected_responses.size();
      end
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench for the circular list manager
// Drives a directed opening and then biased random requests through three
// sender idling phases; the checker predicts and scores every response.
// ----------------------------------------------------------------------------
module tb;
   import clm_pkg::*;

   // func code the block must ignore; the package gives it no name
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 730;
   localparam int         BLOCK_ITEMS  = 120;
   // longest legitimate quiet stretch is a full ring walk plus a sender gap
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_responses;
   int requests_seen;
   int refused_inserts;
   int empty_deletes;
   int missed_deletes;
   int peak_nodes;

   int idle_pct = 0;
   int stall_cycles = 0;

   logic signed [31:0] value_pool [16];

   circular_list_manager dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   list_response_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .pending_responses (pending_responses),
      .requests_seen     (requests_seen),
      .refused_inserts   (refused_inserts),
      .empty_deletes     (empty_deletes),
      .missed_deletes    (missed_deletes),
      .peak_nodes        (peak_nodes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold start low for a random number of whole cycles, then present the
   // request at a falling edge and keep it there until an edge finds busy low.
   task automatic send_request(input logic [1:0] func, input logic signed [31:0] value);
      req_type r;
      r.func       = func;
      r.item_value = value;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Draw a value mostly from the pool so that deletes find their victims;
   // now and then refresh a pool slot with a fresh full-width value.
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      if ($urandom_range(9) < 8) begin
         v = value_pool[$urandom_range(15)];
      end else begin
         v = $urandom;
         value_pool[$urandom_range(15)] = v;
      end
      return v;
   endfunction

   // Watchdog: give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", stall_cycles);
         $display("circular_list_manager test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [1:0] func;
      int         ins_pct;
      int         pick;

      for (int i = 0; i < 16; i++)
         value_pool[i] = $urandom;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = '0;
      value_pool[3] = -32'sd1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening: empty list, extremes of the value field, tail and
      // head removal, a miss, duplicates and the unused func code.
      idle_pct = 13;
      send_request(FUNC_DELETE,   32'sd7);             // delete from empty list
      send_request(FUNC_UNUSED,   32'sd9);             // ignored on empty list
      send_request(FUNC_INS_HEAD, 32'sh8000_0000);     // first node, both ends
      send_request(FUNC_INS_TAIL, 32'sh7fff_ffff);
      send_request(FUNC_INS_HEAD, 32'sd0);
      send_request(FUNC_INS_TAIL, -32'sd1);
      send_request(FUNC_INS_TAIL, 32'sh5555_5555);
      send_request(FUNC_INS_HEAD, 32'shaaaa_aaaa);
      send_request(FUNC_DELETE,   32'sd12345);         // no match
      send_request(FUNC_DELETE,   32'sh5555_5555);     // tail falls back a node
      send_request(FUNC_INS_TAIL, 32'sd3);             // relies on the moved tail
      send_request(FUNC_DELETE,   32'shaaaa_aaaa);     // head removal
      send_request(FUNC_DELETE,   32'sh7fff_ffff);     // middle removal
      send_request(FUNC_INS_TAIL, 32'sd0);             // duplicate of the head
      send_request(FUNC_DELETE,   32'sd0);             // first match only
      send_request(FUNC_UNUSED,   32'sd0);             // ignored on a live list
      send_request(FUNC_DELETE,   32'sd0);             // now the tail
      send_request(FUNC_DELETE,   -32'sd1);
      send_request(FUNC_DELETE,   32'sd3);
      send_request(FUNC_DELETE,   32'sh8000_0000);     // last node goes
      send_request(FUNC_DELETE,   32'sh8000_0000);     // empty again
      send_request(FUNC_INS_HEAD, 32'sd42);
      send_request(FUNC_DELETE,   32'sd42);

      // Random part in blocks that lean towards filling, draining or mixing,
      // so the store runs full and the ring runs dry several times over.
      ins_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            case ((i / BLOCK_ITEMS) % 3)
               0:       ins_pct = 85;
               1:       ins_pct = 20;
               default: ins_pct = 50;
            endcase
         end
         if (i < RANDOM_ITEMS / 3)
            idle_pct = 13;
         else if (i < 2 * RANDOM_ITEMS / 3)
            idle_pct = 74;
         else
            idle_pct = 0;
         pick = $urandom_range(99);
         if (pick < 3)
            func = FUNC_UNUSED;
         else if (pick < 3 + ins_pct * 97 / 100)
            func = $urandom_range(1) ? FUNC_INS_TAIL : FUNC_INS_HEAD;
         else
            func = FUNC_DELETE;
         send_request(func, pick_value());
      end

      @(negedge clock);
      start = 1'b0;

      // drain outstanding responses, then allow for anything stray
      while (pending_responses != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: %0d refused inserts, %0d deletes on an empty list,",
               requests_seen, refused_inserts, empty_deletes);
      $display("%0d deletes without a match, ring peaked at %0d nodes, %0d mismatches",
               missed_deletes, peak_nodes, mismatch_count);
      if (mismatch_count == 0)
         $display("circular_list_manager test passed");
      else
         $display("circular_list_manager test failed");
      $finish;
   end

endmodule
